// ----- rtl/sarsa_lambda_update_defines.svh -----
// Assertion macros shared by the SARSA(lambda) update block.
`ifndef SARSA_LAMBDA_UPDATE_DEFINES_SVH
`define SARSA_LAMBDA_UPDATE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SARSA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SARSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sarsa_pkg.sv -----
// Types, codes and helpers shared by the SARSA(lambda) update block.
`default_nettype none

package sarsa_pkg;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    localparam logic [1:0] CMD_TRACE  = 2'd0;
    localparam logic [1:0] CMD_DIRECT = 2'd1;
    localparam logic [1:0] CMD_END    = 2'd2;
    localparam logic [1:0] CMD_FILL   = 2'd3;

    localparam logic [2:0] CFG_DISCOUNT    = 3'd0;
    localparam logic [2:0] CFG_TRACE_DECAY = 3'd1;
    localparam logic [2:0] CFG_RATE        = 3'd2;
    localparam logic [2:0] CFG_BASELINE    = 3'd3;
    localparam logic [2:0] CFG_INITIAL     = 3'd4;

    localparam logic [2:0] JOB_NONE   = 3'd0;
    localparam logic [2:0] JOB_TRACE  = 3'd1;
    localparam logic [2:0] JOB_DIRECT = 3'd2;
    localparam logic [2:0] JOB_CLR    = 3'd3;
    localparam logic [2:0] JOB_FILL   = 3'd4;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] reward;
        logic [5:0]         cur_state;
        logic [1:0]         cur_action;
        logic [5:0]         nxt_state;
        logic [1:0]         nxt_action;
    } sarsa_in_t;

    typedef struct packed {
        logic signed [31:0] td_error;
        logic               td_valid;
    } sarsa_out_t;

    // Sequencer commands to the datapath for one cycle.
    typedef struct packed {
        logic rd_en;
        logic upd_en;
        logic trace_mode;
        logic vn_cap;
        logic vp_cap;
        logic td_mul;
        logic td_calc;
        logic val_wr;
        logic val_fill;
        logic trc_wr;
    } sarsa_ctl_t;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -36'sh0_8000_0000)
            r = -32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/sarsa_ctrl.sv -----
// Sequencer that walks the table and drives the shared update pipeline.
`default_nettype none

module sarsa_ctrl
    import sarsa_pkg::*;
#(
    parameter int ENTRIES = 256
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   go,
    input  wire logic [2:0]                             job,
    input  wire logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] nidx,
    input  wire logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] uidx,
    input  wire logic                                   pipe_busy,
    output sarsa_ctl_t                                  ctl,
    output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] addr,
    output logic                                        busy,
    output logic                                        done
);

    localparam int IDX_W = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_RD_N  = 4'd2;
    localparam logic [3:0] ST_RD_U  = 4'd3;
    localparam logic [3:0] ST_MUL   = 4'd4;
    localparam logic [3:0] ST_TD    = 4'd5;
    localparam logic [3:0] ST_SWEEP = 4'd6;
    localparam logic [3:0] ST_ONE   = 4'd7;
    localparam logic [3:0] ST_DRAIN = 4'd8;
    localparam logic [3:0] ST_WIPE  = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    logic [3:0]       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [2:0]       job_reg, job_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            job_reg   <= JOB_NONE;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            job_reg   <= job_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        job_next   = job_reg;
        ctl        = '0;
        addr       = cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                ctl.val_wr = 1'b1;
                ctl.trc_wr = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (go)
                begin
                    job_next = job;
                    cnt_next = '0;
                    if (job inside {JOB_TRACE, JOB_DIRECT})
                        state_next = ST_RD_N;
                    else if (job inside {JOB_CLR, JOB_FILL})
                        state_next = ST_WIPE;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_RD_N:
            begin
                ctl.rd_en  = 1'b1;
                addr       = nidx;
                state_next = ST_RD_U;
            end
            ST_RD_U:
            begin
                ctl.rd_en  = 1'b1;
                ctl.vn_cap = 1'b1;
                addr       = uidx;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                ctl.vp_cap = 1'b1;
                ctl.td_mul = 1'b1;
                state_next = ST_TD;
            end
            ST_TD:
            begin
                ctl.td_calc = 1'b1;
                state_next  = (job_reg == JOB_TRACE) ? ST_SWEEP : ST_ONE;
            end
            ST_SWEEP:
            begin
                ctl.rd_en      = 1'b1;
                ctl.upd_en     = 1'b1;
                ctl.trace_mode = 1'b1;
                cnt_next       = cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_ONE:
            begin
                ctl.rd_en  = 1'b1;
                ctl.upd_en = 1'b1;
                addr       = uidx;
                state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!pipe_busy)
                    state_next = ST_DONE;
            end
            ST_WIPE:
            begin
                if (job_reg == JOB_FILL)
                begin
                    ctl.val_wr   = 1'b1;
                    ctl.val_fill = 1'b1;
                end
                else
                begin
                    ctl.trc_wr = 1'b1;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

endmodule

`default_nettype wire

// ----- rtl/sarsa_dpath.sv -----
// Value and trace memories with the shared four-stage entry update pipeline.
`default_nettype none

module sarsa_dpath
    import sarsa_pkg::*;
#(
    parameter int ENTRIES = 256
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire sarsa_ctl_t                             ctl,
    input  wire logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] addr,
    input  wire logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] uidx,
    input  wire logic [16:0]                            gamma,
    input  wire logic [16:0]                            lambda_f,
    input  wire logic [16:0]                            alpha,
    input  wire logic signed [32:0]                     rb,
    input  wire logic signed [31:0]                     init_val,
    output logic signed [31:0]                          td,
    output logic                                        pipe_busy
);

    localparam int IDX_W = ENTRIES > 1 ? $clog2(ENTRIES) : 1;

    logic signed [31:0] vmem [ENTRIES];
    logic [16:0]        tmem [ENTRIES];

    logic signed [31:0] vrd_reg;
    logic [16:0]        trd_reg;

    logic               a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg;
    logic               a_tm_reg, b_tm_reg;
    logic [IDX_W-1:0]   a_idx_reg, b_idx_reg, c_idx_reg, d_idx_reg;
    logic signed [31:0] b_v_reg, c_v_reg, d_v_reg;
    logic [32:0]        b_m1_reg;
    logic [32:0]        c_m2_reg;
    logic signed [49:0] d_m3_reg;

    logic signed [31:0] vn_reg, vp_reg, td_reg;

    logic [33:0]        m1, m2;
    logic [16:0]        tn;
    logic [16:0]        op_a;
    logic signed [31:0] op_b;
    logic signed [49:0] m3;
    logic signed [35:0] td_sum, d_sum;

    // Memory read port, registered.
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            vrd_reg <= vmem[addr];
            trd_reg <= tmem[addr];
        end
    end

    // Pipeline stage valids.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= ctl.upd_en;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
        end
    end

    assign m1 = {17'd0, trd_reg} * {17'd0, lambda_f};
    // The trace of the previous pair is replaced by one; a direct update uses one too.
    assign tn = (!b_tm_reg || b_idx_reg == uidx) ? ONE_Q16 : b_m1_reg[32:16];
    assign m2 = {17'd0, tn} * {17'd0, alpha};

    // The last multiplier also forms the discounted next value for the TD error.
    assign op_a = ctl.td_mul ? gamma : c_m2_reg[32:16];
    assign op_b = ctl.td_mul ? vn_reg : td_reg;
    assign m3   = $signed({1'b0, op_a}) * op_b;

    assign d_sum  = 36'(d_v_reg) + 36'(d_m3_reg >>> 16);
    assign td_sum = 36'(rb) + 36'(d_m3_reg >>> 16) - 36'(vp_reg);

    always_ff @(posedge clk)
    begin
        a_idx_reg <= addr;
        a_tm_reg  <= ctl.trace_mode;
        b_idx_reg <= a_idx_reg;
        b_tm_reg  <= a_tm_reg;
        b_v_reg   <= vrd_reg;
        b_m1_reg  <= m1[32:0];
        c_idx_reg <= b_idx_reg;
        c_v_reg   <= b_v_reg;
        c_m2_reg  <= m2[32:0];
        d_idx_reg <= c_idx_reg;
        d_v_reg   <= c_v_reg;
        d_m3_reg  <= m3;
        if (ctl.vn_cap)
            vn_reg <= vrd_reg;
        if (ctl.vp_cap)
            vp_reg <= vrd_reg;
        if (ctl.td_calc)
            td_reg <= sat32(td_sum);
    end

    always_ff @(posedge clk)
    begin
        if (d_vld_reg)
            vmem[d_idx_reg] <= sat32(d_sum);
        else if (ctl.val_wr)
            vmem[addr] <= ctl.val_fill ? init_val : 32'sd0;
    end

    always_ff @(posedge clk)
    begin
        if (b_vld_reg && b_tm_reg)
            tmem[b_idx_reg] <= tn;
        else if (ctl.trc_wr)
            tmem[addr] <= '0;
    end

    assign td        = td_reg;
    assign pipe_busy = a_vld_reg | b_vld_reg | c_vld_reg | d_vld_reg;

endmodule

`default_nettype wire

// ----- rtl/sarsa_lambda_update.sv -----
// Top level of the tabular SARSA(lambda) learner with replacing traces.
//
//   Channel   Ports                          Handshake
//   item      start, busy, item              taken when start is high and busy low
//   result    result_valid, result           one-cycle strobe, cannot be held off
//   config    cfg_we, cfg_index, cfg_data    written on any edge with cfg_we high
//
// Once start is taken, a trace update reads both values and forms the TD error in the
// states RD_N, RD_U, MUL and TD, sweeps every table entry through the shared
// pipeline, waits in DRAIN until that pipeline is empty, finishes in DONE and then
// strobes the result. A direct update sends one entry in place of the sweep; end of
// episode and fill make a single pass over the table, and an item that changes nothing
// goes straight to DONE. After reset a clearing pass over every entry zeroes both
// tables while busy is high. The result is always delivered; nothing stalls it.
`default_nettype none

module sarsa_lambda_update
    import sarsa_pkg::*;
#(
    parameter int NUM_STATES  = 64,
    parameter int NUM_ACTIONS = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire sarsa_in_t   item,
    output logic             result_valid,
    output sarsa_out_t       result,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

`include "sarsa_lambda_update_defines.svh"

    localparam int ENTRIES = NUM_STATES * NUM_ACTIONS;
    localparam int IDX_W   = ENTRIES > 1 ? $clog2(ENTRIES) : 1;

    function automatic logic [16:0] clamp_factor(input logic [16:0] v);
        return (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

    logic [16:0]        discount_reg, decay_reg, rate_reg;
    logic signed [31:0] baseline_reg, initial_reg;

    logic [5:0]         prev_state_reg;
    logic [1:0]         prev_action_reg;
    logic               prev_valid_reg;

    logic [IDX_W-1:0]   nidx_reg, uidx_reg;
    logic signed [32:0] rb_reg;
    logic               tdv_reg;

    logic               result_valid_reg;
    sarsa_out_t         result_reg;

    logic               accept;
    logic               ns_ok, na_ok, cs_ok, ca_ok;
    logic [2:0]         job;
    logic [31:0]        nidx_w, cidx_w, pidx_w;

    sarsa_ctl_t         ctl;
    logic [IDX_W-1:0]   addr;
    logic               pipe_busy;
    logic               done;
    logic signed [31:0] td;

    assign accept = start && !busy;

    assign ns_ok = 32'(item.nxt_state) < NUM_STATES;
    assign na_ok = 32'(item.nxt_action) < NUM_ACTIONS;
    assign cs_ok = 32'(item.cur_state) < NUM_STATES;
    assign ca_ok = 32'(item.cur_action) < NUM_ACTIONS;

    assign nidx_w = 32'(32'(item.nxt_state) * NUM_ACTIONS) + 32'(item.nxt_action);
    assign cidx_w = 32'(32'(item.cur_state) * NUM_ACTIONS) + 32'(item.cur_action);
    assign pidx_w = 32'(32'(prev_state_reg) * NUM_ACTIONS) + 32'(prev_action_reg);

    always_comb
    begin
        job = JOB_NONE;
        case (item.command)
            CMD_TRACE:
            begin
                if (ns_ok && na_ok && prev_valid_reg)
                    job = JOB_TRACE;
            end
            CMD_DIRECT:
            begin
                if (ns_ok && na_ok && cs_ok && ca_ok)
                    job = JOB_DIRECT;
            end
            CMD_END:  job = JOB_CLR;
            CMD_FILL: job = JOB_FILL;
            default:  job = JOB_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            discount_reg <= ONE_Q16;
            decay_reg    <= '0;
            rate_reg     <= 17'd6554;
            baseline_reg <= '0;
            initial_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DISCOUNT:    discount_reg <= clamp_factor(cfg_data[16:0]);
                CFG_TRACE_DECAY: decay_reg    <= clamp_factor(cfg_data[16:0]);
                CFG_RATE:        rate_reg     <= clamp_factor(cfg_data[16:0]);
                CFG_BASELINE:    baseline_reg <= cfg_data;
                CFG_INITIAL:     initial_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // A taken trace item moves the remembered pair on; its old index is kept for the work.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_state_reg  <= '0;
            prev_action_reg <= '0;
            prev_valid_reg  <= 1'b0;
            tdv_reg         <= 1'b0;
        end
        else if (accept)
        begin
            tdv_reg <= (job == JOB_TRACE) || (job == JOB_DIRECT);
            if (item.command == CMD_TRACE && ns_ok && na_ok)
            begin
                prev_state_reg  <= item.nxt_state;
                prev_action_reg <= item.nxt_action;
                prev_valid_reg  <= 1'b1;
            end
            else if (item.command == CMD_END)
            begin
                prev_state_reg  <= '0;
                prev_action_reg <= '0;
                prev_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            nidx_reg <= nidx_w[IDX_W-1:0];
            uidx_reg <= (item.command == CMD_TRACE) ? pidx_w[IDX_W-1:0] : cidx_w[IDX_W-1:0];
            rb_reg   <= 33'(item.reward) - 33'(baseline_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= done;
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            result_reg.td_error <= tdv_reg ? td : 32'sd0;
            result_reg.td_valid <= tdv_reg;
        end
    end

    sarsa_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (accept),
        .job       (job),
        .nidx      (nidx_reg),
        .uidx      (uidx_reg),
        .pipe_busy (pipe_busy),
        .ctl       (ctl),
        .addr      (addr),
        .busy      (busy),
        .done      (done)
    );

    sarsa_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .addr      (addr),
        .uidx      (uidx_reg),
        .gamma     (discount_reg),
        .lambda_f  (decay_reg),
        .alpha     (rate_reg),
        .rb        (rb_reg),
        .init_val  (initial_reg),
        .td        (td),
        .pipe_busy (pipe_busy)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `SARSA_ASSERT_SAME(a_zero_without_update, result_valid && !result.td_valid, result.td_error == 32'sd0, "td_error is not zero on an item without update")
    `SARSA_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "block not busy after taking an item")
    `SARSA_ASSERT_SAME(a_multiplier_free, ctl.td_mul, !pipe_busy, "TD multiply overlaps entries in the pipeline")
    `SARSA_ASSERT_SAME(a_result_after_work, result_valid, $past(busy), "result strobe without preceding work")

endmodule

`default_nettype wire
